@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'd1;
    localparam logic [3:0] TEXT_COLOR_RESET = 4'd7;
    localparam logic [3:0] BACK_COLOR_RESET = 4'd0;

    // Command queue between the front and back parts; depth is a power of two.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic [15:0] cell_data;
        logic        scrolled;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [10:0] idx;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_SCROLL_COPY,
        ST_SCROLL_BLANK,
        ST_SCROLL_END
    } state_t;

endpackage

`default_nettype wire

@@ rtl/tcw_front.sv @@
`default_nettype none

module tcw_front
    import tcw_pkg::*;
(
    input  wire in_item_t item,
    input  wire logic     push,
    output logic          full,
    input  wire logic     q_full,
    input  wire logic     init_busy,
    output logic          q_push,
    output cmd_t          q_cmd
);

    always_comb
    begin
        q_cmd.ch = item.char_code;
        q_cmd.idx = item.cell_index;
        case (item.req_type)
            REQ_WRITE:
            begin
                q_cmd.op = (item.char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_WRITE;
            end
            REQ_CLEAR: q_cmd.op = OP_CLEAR;
            REQ_READ:  q_cmd.op = OP_READ;
            default:   q_cmd.op = OP_NOP;
        endcase
    end

    assign full = q_full || init_busy;
    assign q_push = push && !full;

endmodule

`default_nettype wire

@@ rtl/tcw_fifo.sv @@
`default_nettype none

module tcw_fifo
    import tcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      valid
);

    cmd_t cmd_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cmd_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assign rd_data = cmd_mem[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full = (count_reg == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

@@ rtl/tcw_back.sv @@
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  cmd_valid,
    input  wire cmd_t                  cmd,
    output logic                       cmd_pop,
    output logic                       init_busy,
    output logic                       empty,
    input  wire logic                  pop,
    output out_item_t                  result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(ROWS + 1);

    logic [15:0] cells_mem [CELLS];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    cmd_t cur_reg, cur_next;
    logic out_valid_reg, out_valid_next;
    out_item_t result_reg, result_next;
    logic [3:0] text_color_reg;
    logic [3:0] back_color_reg;
    logic [15:0] rdata_reg;

    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0] mem_wdata;
    logic mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic slot_free;
    logic wrap;
    logic [COL_W-1:0] col1;
    logic [ROW_W-1:0] row1;
    logic done;
    logic [15:0] done_data;
    logic done_scr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= cells_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
            back_color_reg <= BACK_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_COLOR: text_color_reg <= cfg_data;
                REG_BACK_COLOR: back_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        result_reg <= result_next;
    end

    assign slot_free = !out_valid_reg || pop;
    assign wrap = (cmd.op == OP_NEWLINE) || (col_reg >= COL_W'(COLUMNS));
    assign col1 = wrap ? '0 : col_reg;
    assign row1 = wrap ? row_reg + ROW_W'(1) : row_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        cur_next = cur_reg;
        out_valid_next = out_valid_reg && !pop;
        result_next = result_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = BLANK_CELL;
        mem_re = 1'b0;
        mem_raddr = '0;
        cmd_pop = 1'b0;
        done = 1'b0;
        done_data = '0;
        done_scr = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_IDLE;
                    if (state_reg == ST_CLEAR)
                    begin
                        col_next = '0;
                        row_next = '0;
                        done = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    cur_next = cmd;
                    case (cmd.op)
                        OP_WRITE, OP_NEWLINE:
                        begin
                            if (row1 >= ROW_W'(ROWS))
                            begin
                                cnt_next = '0;
                                state_next = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                row_next = row1;
                                col_next = col1;
                                if (cmd.op == OP_WRITE)
                                begin
                                    mem_we = 1'b1;
                                    mem_waddr = ADDR_W'(int'(row1) * COLUMNS + int'(col1));
                                    mem_wdata = {back_color_reg, text_color_reg, cmd.ch};
                                    col_next = col1 + COL_W'(1);
                                end
                                done = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            mem_re = 1'b1;
                            mem_raddr = ADDR_W'(cmd.idx);
                            state_next = ST_READ_WAIT;
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                done = 1'b1;
                done_data = (int'(cur_reg.idx) < CELLS) ? rdata_reg : '0;
                state_next = ST_IDLE;
            end
            ST_SCROLL_COPY:
            begin
                // Each cell is read one row down and written back in the following cycle.
                if (cnt_reg < CNT_W'(COPY_N))
                begin
                    mem_re = 1'b1;
                    mem_raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                    mem_wdata = rdata_reg;
                end
                if (cnt_reg == CNT_W'(COPY_N))
                begin
                    state_next = ST_SCROLL_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SCROLL_BLANK:
            begin
                mem_we = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_SCROLL_END;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SCROLL_END:
            begin
                row_next = ROW_W'(ROWS - 1);
                col_next = '0;
                if (cur_reg.op == OP_WRITE)
                begin
                    mem_we = 1'b1;
                    mem_waddr = ADDR_W'(COPY_N);
                    mem_wdata = {back_color_reg, text_color_reg, cur_reg.ch};
                    col_next = COL_W'(1);
                end
                done = 1'b1;
                done_scr = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done)
        begin
            out_valid_next = 1'b1;
            result_next.cursor_col = 7'(col_next);
            result_next.cursor_row = 5'(row_next);
            result_next.cursor_pos = 11'(int'(row_next) * COLUMNS + int'(col_next));
            result_next.cell_data = done_data;
            result_next.scrolled = done_scr;
        end
    end

    assign init_busy = (state_reg == ST_INIT);
    assign empty = !out_valid_reg;
    assign result = result_reg;

    a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> slot_free)
        else $error("command taken while the result register is occupied");

    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !cmd_pop)
        else $error("command taken during the power-up blanking pass");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS))
        else $error("cursor column beyond the line length");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < ROW_W'(ROWS))
        else $error("cursor row beyond the screen");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (int'(mem_waddr) < CELLS))
        else $error("screen write outside the cell array");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(result_reg)))
        else $error("waiting result beat changed before it was taken");

endmodule

`default_nettype wire

@@ rtl/text_console_char_writer.sv @@
// Channel   Handshake            Payload
// item      push / full          in_item_t: req_type, char_code, cell_index
// result    empty / pop          out_item_t: cursor_col, cursor_row, cursor_pos, ...
// config    cfg_we               cfg_index, cfg_data (text_color, back_color)
//
// A character, newline or unused request completes in the back end's idle state; a read also
// passes through a read-wait state. A scroll moves the rows up and blanks the last; a clear
// blanks every cell. Both are bound by the single write port of the screen memory, which is
// swept one cell per cycle. After reset the screen is blanked while full stays high.
// A two-entry command queue keeps accepting beats while the back end works or a result waits.
`default_nettype none

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_item_t              item,
    output logic                       empty,
    input  wire logic                  pop,
    output out_item_t                  result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic init_busy;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    tcw_front u_front (
        .item      (item),
        .push      (push),
        .full      (full),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    tcw_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_cmd),
        .full    (q_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .valid   (cmd_valid)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
